FILE: src/pagt_pkg.sv
// Shared types and codes for the priority-AND gate tracker.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package pagt_pkg;

    // Width of child indexes, the prefix length and the cursor.
    localparam int CHILD_W = 5;
    // Width of the input action code and of the result kind code.
    localparam int ACTION_W = 2;
    localparam int KIND_W = 3;
    // Stream data bytes are padded up to whole bytes.
    localparam int TDATA_W = 8;
    // Configuration port widths.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;
    // At most this many results leave for one input item.
    localparam int RES_LIMIT = 16;
    localparam int CNT_W = 5;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_FAIL       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ONLINE     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ACTIVATE   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DEACTIVATE = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NONE       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FAILED     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ONLINE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACTIVATE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IMPOSSIBLE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TERMINATED = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHILDREN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPAIRABLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_ACTIVE = 2'd2;

    // Reset value of the child count register.
    localparam logic [CFG_DATA_W-1:0] NUM_CHILDREN_RESET = 5'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic do_event;
        logic do_status;
        logic do_walk;
    } pagt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic event_final;
        logic walk_more;
        logic walk_last;
    } pagt_sts_t;

endpackage

`default_nettype wire

FILE: src/pagt_ctrl.sv
// Sequencing state machine of the priority-AND gate tracker.
// Depends on pagt_pkg for the command and status structs.
`default_nettype none

module pagt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pagt_pkg::pagt_sts_t sts,
    output pagt_pkg::pagt_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVENT  = 4'b0010,
        ST_STATUS = 4'b0100,
        ST_WALK   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Only an idle controller takes a new item.
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.do_event  = 1'b0;
        cmd.do_status = 1'b0;
        cmd.do_walk   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVENT;
                end
            end
            ST_EVENT:
            begin
                if (sts.out_free)
                begin
                    cmd.do_event = 1'b1;
                    state_next   = sts.event_final ? ST_IDLE : ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.do_status = 1'b1;
                    state_next    = sts.walk_more ? ST_WALK : ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (sts.out_free)
                begin
                    cmd.do_walk = 1'b1;
                    if (sts.walk_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/pagt_datapath.sv
// Gate state, configuration registers and result register of the tracker.
// Depends on pagt_pkg for codes, widths and the command and status structs.
`default_nettype none

module pagt_datapath #(
    parameter int MAX_CHILDREN = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire pagt_pkg::pagt_cmd_t                     cmd,
    output pagt_pkg::pagt_sts_t                          sts,
    input  wire logic                                    cfg_valid,
    input  wire logic [pagt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [pagt_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic [pagt_pkg::ACTION_W-1:0]           in_action,
    input  wire logic [pagt_pkg::CHILD_W-1:0]            in_child,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [pagt_pkg::KIND_W-1:0]                  out_kind,
    output logic [pagt_pkg::CHILD_W-1:0]                 out_target,
    output logic                                         out_last
);

    // Configuration registers.
    logic [pagt_pkg::CFG_DATA_W-1:0] num_children_reg;
    logic                            repairable_reg;
    logic                            always_active_reg;

    // Captured input item.
    logic [pagt_pkg::ACTION_W-1:0] action_reg;
    logic [pagt_pkg::CHILD_W-1:0]  child_reg;

    // Gate state.
    logic [MAX_CHILDREN-1:0]      flags_reg, flags_next;
    logic [pagt_pkg::CHILD_W-1:0] prefix_reg, prefix_next;
    logic [pagt_pkg::CHILD_W-1:0] cursor_reg, cursor_next;
    logic                         done_reg, done_next;
    logic                         impossible_reg, impossible_next;
    logic                         terminated_reg, terminated_next;
    logic [pagt_pkg::CNT_W-1:0]   count_reg, count_next;

    // Result register.
    logic                         valid_reg, valid_next;
    logic [pagt_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [pagt_pkg::CHILD_W-1:0] target_reg, target_next;
    logic                         last_reg, last_next;

    // Decoded values.
    logic [pagt_pkg::CHILD_W-1:0] total;
    logic [MAX_CHILDREN-1:0]      child_sel;
    logic                         in_range;
    logic                         child_hit;
    logic                         illegal_online;
    logic                         complete;
    logic [pagt_pkg::CHILD_W-1:0] cursor_start;
    logic                         walk_emits;
    logic                         walk_last;
    logic                         status_change;
    logic                         emit;
    logic [pagt_pkg::KIND_W-1:0]  emit_kind;
    logic [pagt_pkg::CHILD_W-1:0] emit_target;
    logic                         emit_last;

    // Child count saturated into 1..MAX_CHILDREN.
    always_comb
    begin
        if (num_children_reg == '0)
        begin
            total = pagt_pkg::CHILD_W'(1);
        end
        else if (int'(num_children_reg) > MAX_CHILDREN)
        begin
            total = pagt_pkg::CHILD_W'(MAX_CHILDREN);
        end
        else
        begin
            total = num_children_reg;
        end
    end

    // One-hot select of the child named by the item.
    always_comb
    begin
        for (int i = 0; i < MAX_CHILDREN; i++)
        begin
            child_sel[i] = (int'(child_reg) == i + 1);
        end
    end

    assign in_range  = (child_reg != '0) && (child_reg <= total);
    assign child_hit = |(flags_reg & child_sel);
    assign illegal_online = (action_reg == pagt_pkg::ACT_ONLINE) && in_range
                            && (!repairable_reg || !child_hit);

    // Status check and start of an activation walk.
    assign complete      = (prefix_reg >= total);
    assign status_change = (complete != done_reg);
    assign cursor_start  = (!always_active_reg && (cursor_reg == '0))
                           ? pagt_pkg::CHILD_W'(1) : cursor_reg;
    assign walk_emits    = (action_reg == pagt_pkg::ACT_ACTIVATE)
                           && (cursor_start != '0) && (cursor_start <= total);
    assign walk_last     = (cursor_reg >= total)
                           || (count_reg == pagt_pkg::CNT_W'(pagt_pkg::RES_LIMIT - 1));

    // Status to the controller.
    always_comb
    begin
        sts.out_free    = !valid_reg || out_ready;
        sts.event_final = terminated_reg || illegal_online
                          || (action_reg == pagt_pkg::ACT_DEACTIVATE);
        sts.walk_more   = walk_emits;
        sts.walk_last   = walk_last;
    end

    // State update for each processing step.
    always_comb
    begin
        flags_next      = flags_reg;
        prefix_next     = prefix_reg;
        cursor_next     = cursor_reg;
        done_next       = done_reg;
        impossible_next = impossible_reg;
        terminated_next = terminated_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        emit_kind       = pagt_pkg::KIND_NONE;
        emit_target     = '0;
        emit_last       = 1'b0;

        // Event step: apply the fail, online or deactivate action, or report a gate already terminated.
        if (cmd.do_event)
        begin
            if (terminated_reg)
            begin
                emit      = 1'b1;
                emit_kind = pagt_pkg::KIND_TERMINATED;
                emit_last = 1'b1;
            end
            else
            begin
                case (action_reg)
                    pagt_pkg::ACT_FAIL:
                    begin
                        if (in_range && !child_hit)
                        begin
                            flags_next = flags_reg | child_sel;
                            if ({1'b0, child_reg} == {1'b0, prefix_reg} + 6'd1)
                            begin
                                prefix_next = child_reg;
                            end
                        end
                    end
                    pagt_pkg::ACT_ONLINE:
                    begin
                        if (illegal_online)
                        begin
                            impossible_next = 1'b1;
                            terminated_next = 1'b1;
                            emit            = 1'b1;
                            emit_kind       = pagt_pkg::KIND_IMPOSSIBLE;
                            emit_last       = 1'b1;
                        end
                        else if (in_range)
                        begin
                            flags_next = flags_reg & ~child_sel;
                            if (child_reg <= prefix_reg)
                            begin
                                prefix_next = child_reg - pagt_pkg::CHILD_W'(1);
                            end
                        end
                    end
                    pagt_pkg::ACT_DEACTIVATE:
                    begin
                        impossible_next = 1'b1;
                        terminated_next = 1'b1;
                        emit            = 1'b1;
                        emit_kind       = pagt_pkg::KIND_IMPOSSIBLE;
                        emit_last       = 1'b1;
                    end
                    default:
                    begin
                        // Activation is handled in the status and walk steps.
                    end
                endcase
            end
        end

        // Status step: report a change of gate status, or a none result if nothing else follows, and arm the walk.
        if (cmd.do_status)
        begin
            if (status_change)
            begin
                done_next = complete;
                emit      = 1'b1;
                emit_kind = complete ? pagt_pkg::KIND_FAILED : pagt_pkg::KIND_ONLINE;
                emit_last = !walk_emits;
            end
            else if (!walk_emits)
            begin
                emit      = 1'b1;
                emit_kind = pagt_pkg::KIND_NONE;
                emit_last = 1'b1;
            end
            count_next = status_change ? pagt_pkg::CNT_W'(1) : '0;
            if (action_reg == pagt_pkg::ACT_ACTIVATE)
            begin
                cursor_next = (cursor_start > total) ? '0 : cursor_start;
            end
        end

        // Walk step: activate the cursor child and advance.
        if (cmd.do_walk)
        begin
            emit        = 1'b1;
            emit_kind   = pagt_pkg::KIND_ACTIVATE;
            emit_target = cursor_reg;
            emit_last   = walk_last;
            cursor_next = (cursor_reg < total) ? cursor_reg + pagt_pkg::CHILD_W'(1) : '0;
            count_next  = count_reg + pagt_pkg::CNT_W'(1);
        end
    end

    // Result register loads on an emission and drains on acceptance.
    always_comb
    begin
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        target_next = target_reg;
        last_next   = last_reg;
        if (emit)
        begin
            valid_next  = 1'b1;
            kind_next   = emit_kind;
            target_next = emit_target;
            last_next   = emit_last;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Control and gate state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_children_reg  <= pagt_pkg::NUM_CHILDREN_RESET;
            repairable_reg    <= 1'b0;
            always_active_reg <= 1'b0;
            flags_reg         <= '0;
            prefix_reg        <= '0;
            cursor_reg        <= '0;
            done_reg          <= 1'b0;
            impossible_reg    <= 1'b0;
            terminated_reg    <= 1'b0;
            count_reg         <= '0;
            valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    pagt_pkg::REG_NUM_CHILDREN:  num_children_reg  <= cfg_data;
                    pagt_pkg::REG_REPAIRABLE:    repairable_reg    <= cfg_data[0];
                    pagt_pkg::REG_ALWAYS_ACTIVE: always_active_reg <= cfg_data[0];
                    default:
                    begin
                        // Writes beyond the register list are dropped.
                    end
                endcase
            end
            flags_reg      <= flags_next;
            prefix_reg     <= prefix_next;
            cursor_reg     <= cursor_next;
            done_reg       <= done_next;
            impossible_reg <= impossible_next;
            terminated_reg <= terminated_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            child_reg  <= in_child;
        end
        kind_reg   <= kind_next;
        target_reg <= target_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_target = target_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

FILE: src/priority_and_gate_tracker_unit.sv
// Top level of the priority-AND gate tracker: stream ports, controller and datapath.
// Depends on pagt_pkg, pagt_ctrl and pagt_datapath.
//
//  Channel   Direction  Handshake                     Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready   one gate event per item
//  m_axis    out        m_axis_tvalid/m_axis_tready   one or more results per item, tlast on final
//  cfg       in         cfg_valid/cfg_ready           register index and write data
//
// An item is accepted, then runs the event step; unless that ends the item (terminated
// gate, illegal repair or deactivation), a status step follows, and an activation walk
// adds a walk step per activated child. Each step waits on the single result register.
// The next item is accepted in the cycle after the final result is loaded.
// A stalled result register holds the sequencer until it drains.
// Reset clears the gate state and sets num_children to 2; no clearing pass follows.
`default_nettype none

module priority_and_gate_tracker_unit #(
    parameter int MAX_CHILDREN = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: child [4:0], zero pad [7:5]
    input  wire logic [pagt_pkg::TDATA_W-1:0]        s_axis_tdata,
    // tuser: action [1:0]
    input  wire logic [pagt_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: target_child [4:0], zero pad [7:5]
    output logic [pagt_pkg::TDATA_W-1:0]             m_axis_tdata,
    // tuser: kind [2:0]
    output logic [pagt_pkg::KIND_W-1:0]              m_axis_tuser,
    output logic                                     m_axis_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pagt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pagt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pagt_pkg::pagt_cmd_t          cmd;
    pagt_pkg::pagt_sts_t          sts;
    logic [pagt_pkg::CHILD_W-1:0] out_target;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    pagt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pagt_datapath #(
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_action  (s_axis_tuser),
        .in_child   (s_axis_tdata[pagt_pkg::CHILD_W-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_target (out_target),
        .out_last   (m_axis_tlast)
    );

    // Pad the target child up to a whole byte.
    assign m_axis_tdata = {{(pagt_pkg::TDATA_W - pagt_pkg::CHILD_W){1'b0}}, out_target};

endmodule

`default_nettype wire

FILE: src/pagt_checker.sv
// Port-level checks for the priority-AND gate tracker, bound to the top level.
// Depends on pagt_pkg for the result kind codes.
`default_nettype none

module pagt_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [pagt_pkg::TDATA_W-1:0]        m_axis_tdata,
    input wire logic [pagt_pkg::KIND_W-1:0]         m_axis_tuser,
    input wire logic                                m_axis_tlast
);

    logic out_accept;
    logic seen_impossible_reg;

    assign out_accept = m_axis_tvalid && m_axis_tready;

    // Remember that the gate has been reported impossible.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_impossible_reg <= 1'b0;
        end
        else if (out_accept && (m_axis_tuser == pagt_pkg::KIND_IMPOSSIBLE))
        begin
            seen_impossible_reg <= 1'b1;
        end
    end

    // A target child is named exactly on activation results.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser == pagt_pkg::KIND_ACTIVATE) == (m_axis_tdata != '0)))
    else $error("target child does not match result kind");

    // Impossible and terminated results always end their item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser == pagt_pkg::KIND_IMPOSSIBLE)
                           || (m_axis_tuser == pagt_pkg::KIND_TERMINATED)))
            |-> m_axis_tlast)
    else $error("terminal result without tlast");

    // Once impossible, every later result is terminated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && seen_impossible_reg)
            |-> (m_axis_tuser == pagt_pkg::KIND_TERMINATED))
    else $error("result other than terminated after impossible");

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
                 && $stable(m_axis_tlast)))
    else $error("stalled result changed");

    // An item is taken one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken in two consecutive cycles");

endmodule

bind priority_and_gate_tracker_unit pagt_checker u_pagt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: test/tb_priority_and_gate_tracker_unit.sv
// Self-checking testbench for the priority-AND gate tracker: directed and random gate events
// are checked, result by result, against a cycle-free predictor of the gate.
// Depends on pagt_pkg and priority_and_gate_tracker_unit.
`default_nettype none

module tb_priority_and_gate_tracker_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHILDREN = 16;
    // Longest random wait of either side, in cycles.
    localparam int MAX_GAP = 12;
    // Long receiver hold-off that backs the block up into its input.
    localparam int LONG_HOLD = 400;
    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet cycles at the end, to catch stray results.
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 42;
    // Zero padding above the child index in tdata.
    localparam int PAD_W = pagt_pkg::TDATA_W - pagt_pkg::CHILD_W;
    // Bits above the flag bit of a flag register write.
    localparam int UPPER_W = pagt_pkg::CFG_DATA_W - 1;
    // Register index that the block does not use.
    localparam logic [pagt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                          drain_first;
        logic [pagt_pkg::ACTION_W-1:0] action;
        logic [pagt_pkg::CHILD_W-1:0]  child;
    } gate_event_t;

    typedef struct packed {
        logic [pagt_pkg::KIND_W-1:0]  kind;
        logic [pagt_pkg::CHILD_W-1:0] target;
        logic                         last;
    } gate_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pagt_pkg::TDATA_W-1:0]    s_axis_tdata = '0;
    logic [pagt_pkg::ACTION_W-1:0]   s_axis_tuser = pagt_pkg::ACT_FAIL;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [pagt_pkg::TDATA_W-1:0]    m_axis_tdata;
    logic [pagt_pkg::KIND_W-1:0]     m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pagt_pkg::CFG_IDX_W-1:0]  cfg_index = pagt_pkg::REG_NUM_CHILDREN;
    logic [pagt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    priority_and_gate_tracker_unit #(
        .MAX_CHILDREN(MAX_CHILDREN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Items waiting to be offered and results still owed by the block.
    gate_event_t  gate_events[$];
    gate_result_t due_results[$];
    gate_result_t step_out[$];
    gate_event_t  offered;

    // Configuration as written to the block.
    logic [pagt_pkg::CFG_DATA_W-1:0] cfg_num_children = pagt_pkg::NUM_CHILDREN_RESET;
    logic                            cfg_repairable = 1'b0;
    logic                            cfg_always_active = 1'b0;

    // Gate state of the predictor.
    logic [MAX_CHILDREN-1:0]      failed_flags = '0;
    logic [pagt_pkg::CHILD_W-1:0] prefix_len = '0;
    logic [pagt_pkg::CHILD_W-1:0] walk_cursor = '0;
    logic                         done_flag = 1'b0;
    logic                         terminated_flag = 1'b0;

    // Stimulus side view of which children are down, and the child count in use.
    logic [MAX_CHILDREN-1:0] gen_failed = '0;
    int                      gen_total = 2;

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int send_gap = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int results_seen = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Free-running clock.
    initial forever #5 clk = ~clk;

    // Child count register saturated into the supported range.
    function automatic int child_span(input logic [pagt_pkg::CFG_DATA_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > MAX_CHILDREN)
            return MAX_CHILDREN;
        return n;
    endfunction

    function automatic void add_result(input logic [pagt_pkg::KIND_W-1:0] kind,
                                       input logic [pagt_pkg::CHILD_W-1:0] target);
        gate_result_t r;
        r.kind = kind;
        r.target = target;
        r.last = 1'b0;
        if (step_out.size() < pagt_pkg::RES_LIMIT)
            step_out.push_back(r);
    endfunction

    function automatic void mark_impossible();
        terminated_flag = 1'b1;
        add_result(pagt_pkg::KIND_IMPOSSIBLE, '0);
    endfunction

    // Advance the gate by one event and queue the results it must produce.
    function automatic void compute_gate_outputs(input logic [pagt_pkg::ACTION_W-1:0] act,
                                                 input logic [pagt_pkg::CHILD_W-1:0] c);
        int total;
        bit in_range;
        bit complete;
        logic [MAX_CHILDREN-1:0] sel;
        step_out.delete();
        total = child_span(cfg_num_children);
        in_range = (c >= 1) && (c <= total);
        sel = in_range ? (MAX_CHILDREN'(1) << (c - 1)) : '0;

        if (terminated_flag)
        begin
            add_result(pagt_pkg::KIND_TERMINATED, '0);
        end
        else
        begin
            if (act == pagt_pkg::ACT_FAIL)
            begin
                if (in_range && (failed_flags & sel) == 0)
                begin
                    failed_flags |= sel;
                    if (c == prefix_len + 1)
                        prefix_len = c;
                end
            end
            else if (act == pagt_pkg::ACT_ONLINE)
            begin
                if (in_range)
                begin
                    if (!cfg_repairable || (failed_flags & sel) == 0)
                    begin
                        mark_impossible();
                    end
                    else
                    begin
                        failed_flags &= ~sel;
                        if (c <= prefix_len)
                            prefix_len = c - pagt_pkg::CHILD_W'(1);
                    end
                end
            end
            else if (act == pagt_pkg::ACT_DEACTIVATE)
            begin
                mark_impossible();
            end

            if (!terminated_flag)
            begin
                // Gate status is reported before any activation.
                complete = prefix_len >= total;
                if (complete && !done_flag)
                begin
                    done_flag = 1'b1;
                    add_result(pagt_pkg::KIND_FAILED, '0);
                end
                else if (!complete && done_flag)
                begin
                    done_flag = 1'b0;
                    add_result(pagt_pkg::KIND_ONLINE, '0);
                end

                // Walk the children; a walk cut off by the result limit resumes later.
                if (act == pagt_pkg::ACT_ACTIVATE)
                begin
                    if (!cfg_always_active && walk_cursor == 0)
                        walk_cursor = pagt_pkg::CHILD_W'(1);
                    while (walk_cursor != 0 && step_out.size() < pagt_pkg::RES_LIMIT)
                    begin
                        if (walk_cursor > total)
                        begin
                            walk_cursor = '0;
                            break;
                        end
                        add_result(pagt_pkg::KIND_ACTIVATE, walk_cursor);
                        if (walk_cursor < total)
                            walk_cursor = walk_cursor + pagt_pkg::CHILD_W'(1);
                        else
                            walk_cursor = '0;
                    end
                end
            end
        end

        if (step_out.size() == 0)
            add_result(pagt_pkg::KIND_NONE, '0);
        step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            due_results.push_back(step_out[i]);
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s", $realtime, msg);
    endfunction

    // Queue one item and keep the stimulus view of failed children current.
    task automatic queue_event(input logic [pagt_pkg::ACTION_W-1:0] act, input int c,
                               input bit drain);
        gate_event_t ev;
        ev.drain_first = drain;
        ev.action = act;
        ev.child = pagt_pkg::CHILD_W'(c);
        gate_events.push_back(ev);
        if (c >= 1 && c <= gen_total)
        begin
            if (act == pagt_pkg::ACT_FAIL)
                gen_failed[c-1] = 1'b1;
            else if (act == pagt_pkg::ACT_ONLINE)
                gen_failed[c-1] = 1'b0;
        end
    endtask

    // One event that keeps the gate alive: ordered and random failures, legal repairs,
    // activations, and events for children outside the range.
    task automatic queue_wellformed(input bit drain);
        int pick;
        int k;
        int start;
        int c;
        bit found;
        logic [pagt_pkg::ACTION_W-1:0] act;
        pick = $urandom_range(0, 99);
        act = pagt_pkg::ACT_FAIL;
        c = $urandom_range(1, gen_total);
        found = 1'b0;
        if (pick < 40)
        begin
            // The lowest healthy child extends the ordered prefix.
            for (k = gen_total; k >= 1; k--)
                if (!gen_failed[k-1])
                    c = k;
        end
        else if (pick < 55)
        begin
            act = pagt_pkg::ACT_FAIL;
        end
        else if (pick < 75 && cfg_repairable)
        begin
            start = $urandom_range(0, gen_total - 1);
            for (k = 0; k < gen_total; k++)
            begin
                if (!found && gen_failed[(start + k) % gen_total])
                begin
                    c = (start + k) % gen_total + 1;
                    act = pagt_pkg::ACT_ONLINE;
                    found = 1'b1;
                end
            end
        end
        else if (pick < 90)
        begin
            act = pagt_pkg::ACT_ACTIVATE;
            c = $urandom_range(0, 31);
        end
        else
        begin
            // Out-of-range child: ignored by the gate.
            act = $urandom_range(0, 1) ? pagt_pkg::ACT_ONLINE : pagt_pkg::ACT_FAIL;
            c = $urandom_range(0, 1) ? 0 : $urandom_range(gen_total + 1, 31);
        end
        queue_event(act, c, drain);
    endtask

    // Wait until no item is pending and every result has arrived, then align to a clock edge.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (gate_events.size() != 0 || s_axis_tvalid || due_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [pagt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pagt_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            pagt_pkg::REG_NUM_CHILDREN:  cfg_num_children = val;
            pagt_pkg::REG_REPAIRABLE:    cfg_repairable = val[0];
            pagt_pkg::REG_ALWAYS_ACTIVE: cfg_always_active = val[0];
            default: ;
        endcase
    endtask

    // Write every register; the flag registers get random upper bits, which must be ignored.
    task automatic configure(input logic [pagt_pkg::CFG_DATA_W-1:0] n, input bit rep,
                             input bit aa);
        logic [UPPER_W-1:0] upper;
        upper = UPPER_W'($urandom_range(0, 15));
        write_reg(pagt_pkg::REG_NUM_CHILDREN, n);
        write_reg(pagt_pkg::REG_REPAIRABLE, {upper, rep});
        upper = UPPER_W'($urandom_range(0, 15));
        write_reg(pagt_pkg::REG_ALWAYS_ACTIVE, {upper, aa});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, pagt_pkg::CFG_DATA_W'($urandom_range(0, 31)));
        cfg_valid <= 1'b0;
        gen_total = child_span(n);
    endtask

    // Sender: offers queued items, predicts on acceptance, then waits a random gap.
    always @(posedge clk)
    begin : drive_events
        bit offer;
        offer = s_axis_tvalid;
        if (!rst_n)
        begin
            offer = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                compute_gate_outputs(offered.action, offered.child);
                offer = 1'b0;
                send_gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (!offer)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (gate_events.size() != 0 &&
                         !(gate_events[0].drain_first && due_results.size() != 0))
                begin
                    offered = gate_events.pop_front();
                    s_axis_tdata <= {{PAD_W{1'b0}}, offered.child};
                    s_axis_tuser <= offered.action;
                    offer = 1'b1;
                end
            end
        end
        s_axis_tvalid <= offer;
    end

    // Receiver: checks each result against the oldest owed one, then stalls at random.
    always @(posedge clk)
    begin : check_results
        gate_result_t want;
        bit ready;
        ready = 1'b0;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected result: kind %0d tdata 0x%0h last %0b",
                                           m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_axis_tuser !== want.kind ||
                        m_axis_tdata !== {{PAD_W{1'b0}}, want.target} ||
                        m_axis_tlast !== want.last)
                        log_mismatch($sformatf(
                            {"result mismatch: expected kind %0d target %0d last %0b, ",
                             "got kind %0d tdata 0x%0h last %0b"},
                            want.kind, want.target, want.last,
                            m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end
                hold_left = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
                // Once, hold off long enough for the block to stall its input.
                if (!long_hold_done && results_seen >= 150 && gate_events.size() > 8)
                begin
                    hold_left = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
                hold_left--;
            else
                ready = 1'b1;
        end
        m_axis_tready <= ready;
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial
    begin : stimulus
        int phase;
        int k;
        int pick;
        int term_pick;
        int c;
        logic [pagt_pkg::CFG_DATA_W-1:0] n;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: two children, no repair, walks on activation.
        queue_event(pagt_pkg::ACT_ACTIVATE, 0, 1'b0);
        queue_event(pagt_pkg::ACT_FAIL, 0, 1'b0);
        queue_event(pagt_pkg::ACT_FAIL, 31, 1'b0);
        queue_event(pagt_pkg::ACT_ONLINE, 0, 1'b0);
        queue_event(pagt_pkg::ACT_ONLINE, 3, 1'b0);
        queue_event(pagt_pkg::ACT_FAIL, 2, 1'b0);
        queue_event(pagt_pkg::ACT_FAIL, 2, 1'b0);
        queue_event(pagt_pkg::ACT_FAIL, 1, 1'b0);

        // Single child: gate failure, out-of-range repair, repair and failure again.
        wait_idle();
        configure(5'd1, 1'b1, 1'b0);
        queue_event(pagt_pkg::ACT_ACTIVATE, 31, 1'b0);
        queue_event(pagt_pkg::ACT_ONLINE, 2, 1'b0);
        queue_event(pagt_pkg::ACT_ONLINE, 1, 1'b0);
        queue_event(pagt_pkg::ACT_FAIL, 1, 1'b0);

        // Grow to five children and complete the ordered prefix.
        wait_idle();
        configure(5'd5, 1'b1, 1'b0);
        queue_event(pagt_pkg::ACT_ONLINE, 2, 1'b0);
        for (k = 2; k <= 5; k++)
            queue_event(pagt_pkg::ACT_FAIL, k, 1'b0);

        // Sixteen children: gate online plus a walk cut off at the result limit.
        wait_idle();
        configure(5'd16, 1'b1, 1'b0);
        queue_event(pagt_pkg::ACT_ACTIVATE, 16, 1'b0);

        // The cut-off walk resumes even with activation disabled.
        wait_idle();
        configure(5'd16, 1'b1, 1'b1);
        queue_event(pagt_pkg::ACT_ACTIVATE, 1, 1'b0);

        wait_idle();
        configure(5'd5, 1'b1, 1'b0);
        queue_event(pagt_pkg::ACT_ACTIVATE, 0, 1'b0);

        wait_idle();
        configure(5'd16, 1'b1, 1'b0);
        queue_event(pagt_pkg::ACT_ACTIVATE, 0, 1'b0);

        // Shrinking below a pending walk drops the walk.
        wait_idle();
        configure(5'd3, 1'b1, 1'b0);
        queue_event(pagt_pkg::ACT_ACTIVATE, 0, 1'b0);

        // Random phases that keep the gate alive; the first two hit the count extremes.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            pick = $urandom_range(0, 9);
            if (phase == 0)
                configure(5'd31, 1'b1, 1'b0);
            else if (phase == 1)
                configure(5'd0, 1'b0, 1'b1);
            else
            begin
                n = (pick == 0) ? 5'd16 : (pick == 1) ? 5'd0 :
                    pagt_pkg::CFG_DATA_W'($urandom_range(1, 6));
                configure(n, $urandom_range(0, 3) != 0, $urandom_range(0, 2) == 0);
            end
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            for (k = 0; k < PHASE_ITEMS; k++)
                queue_wellformed(k == PHASE_ITEMS / 2);
        end

        // Final phase: one event that makes the gate impossible, then noise on a dead gate.
        wait_idle();
        term_pick = $urandom_range(0, 2);
        configure(pagt_pkg::CFG_DATA_W'($urandom_range(1, 6)), term_pick != 2,
                  $urandom_range(0, 1) != 0);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        queue_event(pagt_pkg::ACT_FAIL, 1, 1'b0);
        for (k = 0; k < 8; k++)
            queue_wellformed(1'b0);
        c = 0;
        if (term_pick == 1)
        begin
            for (k = gen_total; k >= 1; k--)
                if (!gen_failed[k-1])
                    c = k;
            if (c == 0)
                term_pick = 0;
        end
        if (term_pick == 0)
            queue_event(pagt_pkg::ACT_DEACTIVATE, $urandom_range(0, 31), 1'b0);
        else if (term_pick == 1)
            queue_event(pagt_pkg::ACT_ONLINE, c, 1'b0);
        else
            queue_event(pagt_pkg::ACT_ONLINE, 1, 1'b0);
        for (k = 0; k < 24; k++)
            queue_event(pagt_pkg::ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 31), 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
